@@ sv/emgnd_pkg.sv @@
package emgnd_pkg;

  localparam int HOLD_SAMPLES_DEF = 1000;

  localparam int CODE_W     = 10;
  localparam int SCALE_W    = 17;
  localparam int OFFSET_W   = 10;
  localparam int COEF_W     = 20;
  localparam int WEIGHT_W   = 17;
  localparam int TRIG_W     = 15;
  localparam int SAMPLE_W   = 16;
  localparam int ENV_W      = 32;
  localparam int LEVEL_W    = 15;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  // shared multiplier: A carries samples and the envelope, B the coefficients
  localparam int OPA_W  = ENV_W + 1;
  localparam int OPB_W  = COEF_W + 1;
  localparam int PROD_W = OPA_W + OPB_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_SCALE     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_OFFSET    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0         = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1         = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1         = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2         = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE_WEIGHT = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL   = 4'd7;

  localparam logic [SCALE_W-1:0]       RST_INPUT_SCALE     = 17'd43254;
  localparam logic [OFFSET_W-1:0]      RST_INPUT_OFFSET    = 10'd297;
  localparam logic signed [COEF_W-1:0] RST_COEF_B0         = 20'sd65536;
  localparam logic signed [COEF_W-1:0] RST_COEF_B1         = -20'sd124647;
  localparam logic signed [COEF_W-1:0] RST_COEF_A1         = -20'sd118415;
  localparam logic signed [COEF_W-1:0] RST_COEF_A2         = 20'sd59148;
  localparam logic [WEIGHT_W-1:0]      RST_ENVELOPE_WEIGHT = 17'd6554;
  localparam logic [TRIG_W-1:0]        RST_TRIGGER_LEVEL   = 15'd100;

  typedef struct packed {
    logic [SCALE_W-1:0]       scale;
    logic [OFFSET_W-1:0]      offset;
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [WEIGHT_W-1:0]      weight;
    logic [TRIG_W-1:0]        trigger;
  } cfg_t;

  // operand A select
  localparam logic [3:0] A_ZERO   = 4'd0;
  localparam logic [3:0] A_CODE   = 4'd1;
  localparam logic [3:0] A_OFFSET = 4'd2;
  localparam logic [3:0] A_X0     = 4'd3;
  localparam logic [3:0] A_XD1    = 4'd4;
  localparam logic [3:0] A_XD2    = 4'd5;
  localparam logic [3:0] A_YD1    = 4'd6;
  localparam logic [3:0] A_YD2    = 4'd7;
  localparam logic [3:0] A_MAG    = 4'd8;
  localparam logic [3:0] A_ENV    = 4'd9;

  // operand B select
  localparam logic [3:0] B_ZERO  = 4'd0;
  localparam logic [3:0] B_SCALE = 4'd1;
  localparam logic [3:0] B_ONE   = 4'd2;
  localparam logic [3:0] B_B0    = 4'd3;
  localparam logic [3:0] B_B1    = 4'd4;
  localparam logic [3:0] B_A1    = 4'd5;
  localparam logic [3:0] B_A2    = 4'd6;
  localparam logic [3:0] B_W     = 4'd7;
  localparam logic [3:0] B_WC    = 4'd8;

  // accumulator operations
  localparam logic [2:0] ACC_HOLD  = 3'd0;
  localparam logic [2:0] ACC_LOAD  = 3'd1;
  localparam logic [2:0] ACC_ADD   = 3'd2;
  localparam logic [2:0] ACC_SUB   = 3'd3;
  localparam logic [2:0] ACC_ADDSH = 3'd4;

  // write-back operations
  localparam logic [2:0] WB_NONE   = 3'd0;
  localparam logic [2:0] WB_LATCH  = 3'd1;
  localparam logic [2:0] WB_X0     = 3'd2;
  localparam logic [2:0] WB_Y0     = 3'd3;
  localparam logic [2:0] WB_FINISH = 3'd4;

  // jump conditions
  localparam logic [1:0] JC_NEVER    = 2'd0;
  localparam logic [1:0] JC_NO_INPUT = 2'd1;
  localparam logic [1:0] JC_OUT_BUSY = 2'd2;

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] ST_IDLE    = 4'd0;
  localparam logic [PC_W-1:0] ST_SCALE   = 4'd1;
  localparam logic [PC_W-1:0] ST_OFFSET  = 4'd2;
  localparam logic [PC_W-1:0] ST_ROUND_X = 4'd3;
  localparam logic [PC_W-1:0] ST_TAP0    = 4'd4;
  localparam logic [PC_W-1:0] ST_TAP1    = 4'd5;
  localparam logic [PC_W-1:0] ST_TAP2    = 4'd6;
  localparam logic [PC_W-1:0] ST_FB1     = 4'd7;
  localparam logic [PC_W-1:0] ST_FB2     = 4'd8;
  localparam logic [PC_W-1:0] ST_ROUND_Y = 4'd9;
  localparam logic [PC_W-1:0] ST_ENV_NEW = 4'd10;
  localparam logic [PC_W-1:0] ST_ENV_OLD = 4'd11;
  localparam logic [PC_W-1:0] ST_FINISH  = 4'd12;

  typedef struct packed {
    logic [3:0]      a_sel;
    logic [3:0]      b_sel;
    logic [2:0]      acc_op;
    logic [2:0]      wb;
    logic [1:0]      jc;
    logic [PC_W-1:0] target;
    logic [PC_W-1:0] nxt_pc;
  } ctrl_t;

  // microprogram ROM
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c.a_sel  = A_ZERO;
    c.b_sel  = B_ZERO;
    c.acc_op = ACC_HOLD;
    c.wb     = WB_NONE;
    c.jc     = JC_NEVER;
    c.target = ST_IDLE;
    c.nxt_pc = pc + PC_W'(1);
    unique case (pc)
      ST_IDLE: begin
        c.wb = WB_LATCH;
        c.jc = JC_NO_INPUT;
        c.target = ST_IDLE;
      end
      ST_SCALE: begin
        c.a_sel = A_CODE;   c.b_sel = B_SCALE; c.acc_op = ACC_LOAD;
      end
      ST_OFFSET: begin
        c.a_sel = A_OFFSET; c.b_sel = B_ONE;   c.acc_op = ACC_SUB;
      end
      ST_ROUND_X: c.wb = WB_X0;
      ST_TAP0: begin
        c.a_sel = A_X0;     c.b_sel = B_B0;    c.acc_op = ACC_LOAD;
      end
      ST_TAP1: begin
        c.a_sel = A_XD1;    c.b_sel = B_B1;    c.acc_op = ACC_ADD;
      end
      ST_TAP2: begin
        c.a_sel = A_XD2;    c.b_sel = B_B0;    c.acc_op = ACC_ADD;
      end
      ST_FB1: begin
        c.a_sel = A_YD1;    c.b_sel = B_A1;    c.acc_op = ACC_SUB;
      end
      ST_FB2: begin
        c.a_sel = A_YD2;    c.b_sel = B_A2;    c.acc_op = ACC_SUB;
      end
      ST_ROUND_Y: c.wb = WB_Y0;
      ST_ENV_NEW: begin
        c.a_sel = A_MAG;    c.b_sel = B_W;     c.acc_op = ACC_LOAD;
      end
      ST_ENV_OLD: begin
        c.a_sel = A_ENV;    c.b_sel = B_WC;    c.acc_op = ACC_ADDSH;
      end
      ST_FINISH: begin
        c.wb = WB_FINISH;
        c.jc = JC_OUT_BUSY;
        c.target = ST_FINISH;
        c.nxt_pc = ST_IDLE;
      end
      default: c.nxt_pc = ST_IDLE;
    endcase
    return c;
  endfunction

endpackage

@@ sv/emgnd_seq.sv @@
module emgnd_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_busy,
  output logic                in_ready,
  output emgnd_pkg::ctrl_t    uop,
  output logic                fire
);

  logic [emgnd_pkg::PC_W-1:0] pc;
  logic [emgnd_pkg::PC_W-1:0] pc_next;
  logic                       taken;

  assign uop = emgnd_pkg::ucode(pc);

  always_comb begin
    taken = 1'b0;
    case (uop.jc)
      emgnd_pkg::JC_NO_INPUT: taken = !in_valid;
      emgnd_pkg::JC_OUT_BUSY: taken = out_busy;
      default:                taken = 1'b0;
    endcase
  end

  // a taken jump is a wait: the step does no work
  assign fire     = !taken;
  assign in_ready = (uop.jc == emgnd_pkg::JC_NO_INPUT);
  assign pc_next  = taken ? uop.target : uop.nxt_pc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= emgnd_pkg::ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

@@ sv/emgnd_dp.sv @@
module emgnd_dp #(
  parameter int HOLD_SAMPLES = emgnd_pkg::HOLD_SAMPLES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  emgnd_pkg::cfg_t                       cfg,
  input  emgnd_pkg::ctrl_t                      uop,
  input  logic                                  fire,
  input  logic [emgnd_pkg::CODE_W-1:0]          adc_code,
  input  logic                                  out_ready,
  output logic                                  out_busy,
  output logic                                  out_valid,
  output logic signed [emgnd_pkg::SAMPLE_W-1:0] filtered_sample,
  output logic [emgnd_pkg::LEVEL_W-1:0]         envelope_level,
  output logic                                  flex_event,
  output logic                                  release_event
);

  localparam int OPA_W  = emgnd_pkg::OPA_W;
  localparam int OPB_W  = emgnd_pkg::OPB_W;
  localparam int PROD_W = emgnd_pkg::PROD_W;
  localparam int SW     = emgnd_pkg::SAMPLE_W;
  localparam int FW     = emgnd_pkg::FRAC_W;
  localparam int EW     = emgnd_pkg::ENV_W;
  localparam int LW     = emgnd_pkg::LEVEL_W;
  localparam int WW     = emgnd_pkg::WEIGHT_W;
  localparam int HOLD_W = $clog2(HOLD_SAMPLES + 1);
  localparam logic [HOLD_W-1:0] HOLD_VAL = HOLD_W'(HOLD_SAMPLES);
  localparam logic [WW-1:0]     W_ONE    = WW'(2 ** FW);
  localparam logic signed [PROD_W-1:0] S_MAX = PROD_W'(2 ** (SW - 1) - 1);
  localparam logic signed [PROD_W-1:0] S_MIN = -PROD_W'(2 ** (SW - 1));
  localparam logic [EW-1:0] ENV_MAX = {1'b0, {LW{1'b1}}, {FW{1'b0}}};

  logic [emgnd_pkg::CODE_W-1:0] code;
  logic signed [SW-1:0]         x0;
  logic signed [SW-1:0]         xd1;
  logic signed [SW-1:0]         xd2;
  logic signed [SW-1:0]         yd1;
  logic signed [SW-1:0]         yd2;
  logic [LW-1:0]                mag;
  logic [EW-1:0]                env_acc;
  logic [HOLD_W-1:0]            hold;
  logic signed [PROD_W-1:0]     acc;

  logic [WW-1:0]            w_sat;
  logic signed [OPA_W-1:0]  a_op;
  logic signed [OPB_W-1:0]  b_op;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd_q;
  logic signed [SW-1:0]     y_sat;
  logic [LW-1:0]            y_mag;
  logic [EW-1:0]            env_new;
  logic                     crossing;
  logic [HOLD_W-1:0]        hold_dec;
  logic [HOLD_W-1:0]        hold_next;
  logic                     rel;
  logic                     flex;
  logic                     finish;

  assign w_sat = (cfg.weight > W_ONE) ? W_ONE : cfg.weight;

  always_comb begin
    case (uop.a_sel)
      emgnd_pkg::A_CODE:   a_op = OPA_W'(code);
      emgnd_pkg::A_OFFSET: a_op = OPA_W'(cfg.offset);
      emgnd_pkg::A_X0:     a_op = OPA_W'(x0);
      emgnd_pkg::A_XD1:    a_op = OPA_W'(xd1);
      emgnd_pkg::A_XD2:    a_op = OPA_W'(xd2);
      emgnd_pkg::A_YD1:    a_op = OPA_W'(yd1);
      emgnd_pkg::A_YD2:    a_op = OPA_W'(yd2);
      emgnd_pkg::A_MAG:    a_op = OPA_W'(mag);
      emgnd_pkg::A_ENV:    a_op = OPA_W'(env_acc);
      default:             a_op = '0;
    endcase
  end

  always_comb begin
    case (uop.b_sel)
      emgnd_pkg::B_SCALE: b_op = OPB_W'(cfg.scale);
      emgnd_pkg::B_ONE:   b_op = OPB_W'(W_ONE);
      emgnd_pkg::B_B0:    b_op = OPB_W'(cfg.b0);
      emgnd_pkg::B_B1:    b_op = OPB_W'(cfg.b1);
      emgnd_pkg::B_A1:    b_op = OPB_W'(cfg.a1);
      emgnd_pkg::B_A2:    b_op = OPB_W'(cfg.a2);
      emgnd_pkg::B_W:     b_op = OPB_W'(w_sat);
      emgnd_pkg::B_WC:    b_op = OPB_W'(W_ONE - w_sat);
      default:            b_op = '0;
    endcase
  end

  assign prod = a_op * b_op;

  // round Q.16 to nearest, halves away from zero
  assign rnd_q = (acc + (acc[PROD_W-1] ? PROD_W'(2 ** (FW - 1) - 1) : PROD_W'(2 ** (FW - 1))))
                 >>> FW;

  always_comb begin
    if (rnd_q > S_MAX) begin
      y_sat = SW'(S_MAX);
    end else if (rnd_q < S_MIN) begin
      y_sat = SW'(S_MIN);
    end else begin
      y_sat = rnd_q[SW-1:0];
    end
  end

  // most negative sample saturates to the largest magnitude
  assign y_mag = y_sat[SW-1] ? ((y_sat == SW'(S_MIN)) ? {LW{1'b1}} : LW'(-y_sat))
                             : y_sat[LW-1:0];

  assign env_new  = acc[EW-1:0];
  assign crossing = (EW + 1)'({mag, {FW{1'b0}}}) >=
                    ((EW + 1)'(env_new) + (EW + 1)'({cfg.trigger, {FW{1'b0}}}));

  assign hold_dec  = (hold != '0) ? hold - HOLD_W'(1) : '0;
  assign rel       = (hold == HOLD_W'(1));
  assign flex      = crossing && (hold_dec == '0);
  assign hold_next = crossing ? HOLD_VAL : hold_dec;

  assign out_busy = out_valid && !out_ready;
  assign finish   = fire && (uop.wb == emgnd_pkg::WB_FINISH);

  always_ff @(posedge clk) begin
    if (fire) begin
      case (uop.acc_op)
        emgnd_pkg::ACC_LOAD:  acc <= prod;
        emgnd_pkg::ACC_ADD:   acc <= acc + prod;
        emgnd_pkg::ACC_SUB:   acc <= acc - prod;
        emgnd_pkg::ACC_ADDSH: acc <= acc + (prod >>> FW);
        default:              acc <= acc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      case (uop.wb)
        emgnd_pkg::WB_LATCH: code <= adc_code;
        emgnd_pkg::WB_X0:    x0   <= rnd_q[SW-1:0];
        emgnd_pkg::WB_Y0:    mag  <= y_mag;
        emgnd_pkg::WB_FINISH: begin
          filtered_sample <= yd1;
          envelope_level  <= env_new[FW+LW-1:FW];
          flex_event      <= flex;
          release_event   <= rel;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xd1       <= '0;
      xd2       <= '0;
      yd1       <= '0;
      yd2       <= '0;
      env_acc   <= '0;
      hold      <= '0;
      out_valid <= 1'b0;
    end else begin
      // shift the filter history once the new output is known
      if (fire && (uop.wb == emgnd_pkg::WB_Y0)) begin
        xd2 <= xd1;
        xd1 <= x0;
        yd2 <= yd1;
        yd1 <= y_sat;
      end
      if (finish) begin
        env_acc   <= env_new;
        hold      <= hold_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_hold_max: assert property (@(posedge clk) disable iff (rst) hold <= HOLD_VAL)
    else $error("hold counter above reload value");

  a_env_bound: assert property (@(posedge clk) disable iff (rst) env_acc <= ENV_MAX)
    else $error("envelope above largest magnitude");

  a_flex_reload: assert property (@(posedge clk) disable iff (rst)
    out_valid && flex_event |-> hold == HOLD_VAL)
    else $error("flex word without hold reload");

  a_release_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && release_event && !flex_event |-> hold == '0)
    else $error("release word with hold still running");
`endif

endmodule

@@ sv/emg_notch_envelope_detector.sv @@
// A new word is taken only at the idle step, once the last word is done; the
// microprogram drives one shared multiplier-accumulator for every product,
// one product per step.
// A waiting result holds the program at its last step until it is taken.
// Reset (rst, synchronous, active high) zeroes filter history, envelope and
// hold counter, restarts the sequencer and restores register defaults.
module emg_notch_envelope_detector #(
  parameter int HOLD_SAMPLES = emgnd_pkg::HOLD_SAMPLES_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [emgnd_pkg::CODE_W-1:0]            adc_code,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [emgnd_pkg::SAMPLE_W-1:0]   filtered_sample,
  output logic [emgnd_pkg::LEVEL_W-1:0]           envelope_level,
  output logic                                    flex_event,
  output logic                                    release_event,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [emgnd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [emgnd_pkg::CFG_DATA_W-1:0]        cfg_data
);

  emgnd_pkg::cfg_t  cfg;
  emgnd_pkg::ctrl_t uop;
  logic             fire;
  logic             out_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale   <= emgnd_pkg::RST_INPUT_SCALE;
      cfg.offset  <= emgnd_pkg::RST_INPUT_OFFSET;
      cfg.b0      <= emgnd_pkg::RST_COEF_B0;
      cfg.b1      <= emgnd_pkg::RST_COEF_B1;
      cfg.a1      <= emgnd_pkg::RST_COEF_A1;
      cfg.a2      <= emgnd_pkg::RST_COEF_A2;
      cfg.weight  <= emgnd_pkg::RST_ENVELOPE_WEIGHT;
      cfg.trigger <= emgnd_pkg::RST_TRIGGER_LEVEL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        emgnd_pkg::REG_INPUT_SCALE:     cfg.scale   <= cfg_data[emgnd_pkg::SCALE_W-1:0];
        emgnd_pkg::REG_INPUT_OFFSET:    cfg.offset  <= cfg_data[emgnd_pkg::OFFSET_W-1:0];
        emgnd_pkg::REG_COEF_B0:         cfg.b0      <= cfg_data[emgnd_pkg::COEF_W-1:0];
        emgnd_pkg::REG_COEF_B1:         cfg.b1      <= cfg_data[emgnd_pkg::COEF_W-1:0];
        emgnd_pkg::REG_COEF_A1:         cfg.a1      <= cfg_data[emgnd_pkg::COEF_W-1:0];
        emgnd_pkg::REG_COEF_A2:         cfg.a2      <= cfg_data[emgnd_pkg::COEF_W-1:0];
        emgnd_pkg::REG_ENVELOPE_WEIGHT: cfg.weight  <= cfg_data[emgnd_pkg::WEIGHT_W-1:0];
        emgnd_pkg::REG_TRIGGER_LEVEL:   cfg.trigger <= cfg_data[emgnd_pkg::TRIG_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  emgnd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .in_ready (in_ready),
    .uop      (uop),
    .fire     (fire)
  );

  emgnd_dp #(
    .HOLD_SAMPLES (HOLD_SAMPLES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .uop             (uop),
    .fire            (fire),
    .adc_code        (adc_code),
    .out_ready       (out_ready),
    .out_busy        (out_busy),
    .out_valid       (out_valid),
    .filtered_sample (filtered_sample),
    .envelope_level  (envelope_level),
    .flex_event      (flex_event),
    .release_event   (release_event)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int CODE_W     = emgnd_pkg::CODE_W;
  localparam int SCALE_W    = emgnd_pkg::SCALE_W;
  localparam int OFFSET_W   = emgnd_pkg::OFFSET_W;
  localparam int COEF_W     = emgnd_pkg::COEF_W;
  localparam int WEIGHT_W   = emgnd_pkg::WEIGHT_W;
  localparam int TRIG_W     = emgnd_pkg::TRIG_W;
  localparam int SAMPLE_W   = emgnd_pkg::SAMPLE_W;
  localparam int ENV_W      = emgnd_pkg::ENV_W;
  localparam int LEVEL_W    = emgnd_pkg::LEVEL_W;
  localparam int FRAC_W     = emgnd_pkg::FRAC_W;
  localparam int CFG_IDX_W  = emgnd_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = emgnd_pkg::CFG_DATA_W;

  localparam int HOLD_LEN = emgnd_pkg::HOLD_SAMPLES_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [CFG_IDX_W-1:0] REG_LAST = emgnd_pkg::REG_TRIGGER_LEVEL;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filt;
    logic [LEVEL_W-1:0]         level;
    logic                       flex_ev;
    logic                       rel_ev;
  } detector_out_t;

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_SPARSE} rx_mode_t;

  class notch_envelope_tracker;
    emgnd_pkg::cfg_t regs;
    longint          xd1, xd2, yd1, yd2;
    bit [ENV_W-1:0]  env_acc;
    int              hold_cnt;
    int              errors;
    detector_out_t   pending_results[$];

    function new();
      regs.scale   = emgnd_pkg::RST_INPUT_SCALE;
      regs.offset  = emgnd_pkg::RST_INPUT_OFFSET;
      regs.b0      = emgnd_pkg::RST_COEF_B0;
      regs.b1      = emgnd_pkg::RST_COEF_B1;
      regs.a1      = emgnd_pkg::RST_COEF_A1;
      regs.a2      = emgnd_pkg::RST_COEF_A2;
      regs.weight  = emgnd_pkg::RST_ENVELOPE_WEIGHT;
      regs.trigger = emgnd_pkg::RST_TRIGGER_LEVEL;
      xd1 = 0; xd2 = 0; yd1 = 0; yd2 = 0;
      env_acc = '0;
      hold_cnt = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        emgnd_pkg::REG_INPUT_SCALE:     regs.scale   = data[SCALE_W-1:0];
        emgnd_pkg::REG_INPUT_OFFSET:    regs.offset  = data[OFFSET_W-1:0];
        emgnd_pkg::REG_COEF_B0:         regs.b0      = data[COEF_W-1:0];
        emgnd_pkg::REG_COEF_B1:         regs.b1      = data[COEF_W-1:0];
        emgnd_pkg::REG_COEF_A1:         regs.a1      = data[COEF_W-1:0];
        emgnd_pkg::REG_COEF_A2:         regs.a2      = data[COEF_W-1:0];
        emgnd_pkg::REG_ENVELOPE_WEIGHT: regs.weight  = data[WEIGHT_W-1:0];
        emgnd_pkg::REG_TRIGGER_LEVEL:   regs.trigger = data[TRIG_W-1:0];
        default: ;
      endcase
    endfunction

    function longint round_half_away(longint v);
      if (v >= 0) return (v + 32768) / 65536;
      return -((-v + 32768) / 65536);
    endfunction

    function void take_code(logic [CODE_W-1:0] code);
      longint scaled, x0, acc, y0, mag, w, env_next;
      detector_out_t r;
      scaled = longint'(code) * longint'(regs.scale) - longint'(regs.offset) * 65536;
      x0 = round_half_away(scaled);
      acc = longint'($signed(regs.b0)) * x0 + longint'($signed(regs.b1)) * xd1
          + longint'($signed(regs.b0)) * xd2 - longint'($signed(regs.a1)) * yd1
          - longint'($signed(regs.a2)) * yd2;
      y0 = round_half_away(acc);
      if (y0 > 32767) y0 = 32767;
      if (y0 < -32768) y0 = -32768;
      xd2 = xd1;
      xd1 = x0;
      yd2 = yd1;
      yd1 = y0;

      mag = (y0 < 0) ? -y0 : y0;
      if (mag > 32767) mag = 32767;
      w = longint'(regs.weight);
      if (w > 65536) w = 65536;
      env_next = mag * w + ((longint'(env_acc) * (65536 - w)) >>> 16);
      env_acc = env_next[ENV_W-1:0];

      r.flex_ev = 1'b0;
      r.rel_ev = 1'b0;
      if (hold_cnt > 0) begin
        hold_cnt--;
        if (hold_cnt == 0) r.rel_ev = 1'b1;
      end
      // crossing is judged against the freshly updated envelope
      if (mag * 65536 - env_next >= longint'(regs.trigger) * 65536) begin
        if (hold_cnt == 0) r.flex_ev = 1'b1;
        hold_cnt = HOLD_LEN % 4096;
      end
      r.filt = y0[SAMPLE_W-1:0];
      r.level = env_next[FRAC_W+LEVEL_W-1:FRAC_W];
      pending_results.push_back(r);
    endfunction

    function void note_mismatch(string what, string want_s, string got_s);
      errors++;
      $display("%0t: %s expected %s got %s", $time, what, want_s, got_s);
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] filt, logic [LEVEL_W-1:0] level,
                               logic flex_ev, logic rel_ev);
      detector_out_t want;
      if (pending_results.size() == 0) begin
        note_mismatch("result word", "none", $sformatf("filtered %0d", filt));
        return;
      end
      want = pending_results.pop_front();
      if (filt !== want.filt)
        note_mismatch("filtered_sample", $sformatf("%0d", $signed(want.filt)),
                      $sformatf("%0d", filt));
      if (level !== want.level)
        note_mismatch("envelope_level", $sformatf("%0d", want.level), $sformatf("%0d", level));
      if (flex_ev !== want.flex_ev)
        note_mismatch("flex_event", $sformatf("%0b", want.flex_ev), $sformatf("%0b", flex_ev));
      if (rel_ev !== want.rel_ev)
        note_mismatch("release_event", $sformatf("%0b", want.rel_ev), $sformatf("%0b", rel_ev));
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [CODE_W-1:0]          adc_code = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] filtered_sample;
  logic [LEVEL_W-1:0]         envelope_level;
  logic                       flex_event;
  logic                       release_event;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  notch_envelope_tracker tracker;
  int       burst_left = 0;
  int       streamed = 0;
  int       cycle_count = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  emg_notch_envelope_detector #(.HOLD_SAMPLES(HOLD_LEN)) u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: switch between open, choppy and sparse acceptance now and then
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(40, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) tracker.take_code(adc_code);
      if (out_valid && out_ready)
        tracker.check_result(filtered_sample, envelope_level, flex_event, release_event);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("emg_notch_envelope_detector: mismatch");
      $finish;
    end
  end

  function automatic int pick(int lo, int hi);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic emgnd_pkg::cfg_t random_setup(bit no_cross, bit force_cross);
    emgnd_pkg::cfg_t c;
    c.scale = SCALE_W'(pick(0, 131071));
    c.offset = OFFSET_W'(pick(0, 1023));
    if ($urandom_range(0, 2) != 0) begin
      // stay near the default notch so the loop is mostly stable
      c.b0 = COEF_W'(int'(emgnd_pkg::RST_COEF_B0) + pick(-4096, 4096));
      c.b1 = COEF_W'(int'(emgnd_pkg::RST_COEF_B1) + pick(-4096, 4096));
      c.a1 = COEF_W'(int'(emgnd_pkg::RST_COEF_A1) + pick(-4096, 4096));
      c.a2 = COEF_W'(int'(emgnd_pkg::RST_COEF_A2) + pick(-2048, 2048));
    end else begin
      c.b0 = COEF_W'(pick(-524288, 524287));
      c.b1 = COEF_W'(pick(-524288, 524287));
      c.a1 = COEF_W'(pick(-524288, 524287));
      c.a2 = COEF_W'(pick(-524288, 524287));
    end
    c.weight = ($urandom_range(0, 3) == 0) ? WEIGHT_W'(65536) : WEIGHT_W'(pick(0, 131071));
    c.trigger = ($urandom_range(0, 1) == 0) ? TRIG_W'(pick(0, 800)) : TRIG_W'(pick(0, 32767));
    // full weight makes the envelope equal the magnitude, so the excess is exactly zero:
    // any nonzero level never crosses, a zero level always does
    if (no_cross) begin
      c.weight = WEIGHT_W'($urandom_range(131071, 65536));
      c.trigger = TRIG_W'($urandom_range(32767, 1));
    end
    if (force_cross) begin
      c.weight = WEIGHT_W'($urandom_range(131071, 65536));
      c.trigger = '0;
    end
    return c;
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value, int width);
    logic [CFG_DATA_W-1:0] keep;
    keep = (CFG_DATA_W'(1) << width) - 1'b1;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= (CFG_DATA_W'($urandom()) & ~keep) | (value & keep);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_setup(emgnd_pkg::cfg_t c);
    cfg_write(emgnd_pkg::REG_INPUT_SCALE, CFG_DATA_W'(c.scale), SCALE_W);
    cfg_write(emgnd_pkg::REG_INPUT_OFFSET, CFG_DATA_W'(c.offset), OFFSET_W);
    cfg_write(emgnd_pkg::REG_COEF_B0, c.b0, COEF_W);
    cfg_write(emgnd_pkg::REG_COEF_B1, c.b1, COEF_W);
    cfg_write(emgnd_pkg::REG_COEF_A1, c.a1, COEF_W);
    cfg_write(emgnd_pkg::REG_COEF_A2, c.a2, COEF_W);
    cfg_write(emgnd_pkg::REG_ENVELOPE_WEIGHT, CFG_DATA_W'(c.weight), WEIGHT_W);
    cfg_write(emgnd_pkg::REG_TRIGGER_LEVEL, CFG_DATA_W'(c.trigger), TRIG_W);
    if ($urandom_range(0, 3) == 0)
      cfg_write(REG_LAST + CFG_IDX_W'(1 + $urandom_range(0, 6)), CFG_DATA_W'($urandom()),
                CFG_DATA_W);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_code(logic [CODE_W-1:0] code);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    adc_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic wait_results_done();
    @(posedge clk);
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic play_codes(int codes[$]);
    foreach (codes[i]) send_code(CODE_W'(codes[i]));
    in_valid <= 1'b0;
    wait_results_done();
  endtask

  task automatic stream_codes(int count);
    int lo, spread, v;
    lo = $urandom_range(0, 1023);
    case ($urandom_range(0, 2))
      0:       spread = 6;
      1:       spread = 120;
      default: spread = 1023;
    endcase
    repeat (count) begin
      if ($urandom_range(0, 15) == 0) begin
        v = $urandom_range(0, 1) ? 1023 : 0;
      end else begin
        v = lo + int'($urandom_range(0, spread));
        if (v > 1023) v = 2046 - v;
      end
      send_code(CODE_W'(v));
      streamed++;
    end
    in_valid <= 1'b0;
    wait_results_done();
  endtask

  // run n words without any crossing, in chunks with fresh settings
  task automatic quiet_run(int n);
    int k;
    while (n > 0) begin
      k = $urandom_range(150, 400);
      if (k > n) k = n;
      apply_setup(random_setup(1'b1, 1'b0));
      stream_codes(k);
      n -= k;
    end
  endtask

  initial begin
    emgnd_pkg::cfg_t c;
    tracker = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // first words see cleared filter history
    play_codes('{0, 1023, 0, 1023, 512, 341, 682, 1, 1022});

    c = '{scale: '1, offset: '0, b0: 20'sh7FFFF, b1: 20'sh80000, a1: 20'sh80000,
          a2: 20'sh7FFFF, weight: '1, trigger: '1};
    apply_setup(c);
    play_codes('{1023, 1023, 0, 1023, 0, 0});

    c = '{scale: '0, offset: '1, b0: 20'sh80000, b1: 20'sh7FFFF, a1: 20'sh7FFFF,
          a2: 20'sh80000, weight: '0, trigger: '0};
    apply_setup(c);
    cfg_write(REG_LAST + CFG_IDX_W'(1), '1, CFG_DATA_W);
    cfg_valid <= 1'b0;
    play_codes('{0, 1023, 500, 12});

    while (streamed < 180) begin
      apply_setup(random_setup(1'b0, 1'b0));
      stream_codes($urandom_range(15, 50));
    end

    // open the hold, stop one word short of expiry, then cross on the expiring word
    apply_setup(random_setup(1'b0, 1'b1));
    stream_codes($urandom_range(1, 4));
    quiet_run(tracker.hold_cnt - 1);
    apply_setup(random_setup(1'b0, 1'b1));
    stream_codes($urandom_range(2, 5));

    while (streamed < 1520) begin
      apply_setup(random_setup(1'b0, 1'b0));
      stream_codes($urandom_range(15, 50));
    end

    repeat (24) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0)
      $display("emg_notch_envelope_detector: match");
    else
      $display("emg_notch_envelope_detector: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
sv/emgnd_pkg.sv
sv/emgnd_seq.sv
sv/emgnd_dp.sv
sv/emg_notch_envelope_detector.sv
dv/tb.sv
